/* hdl/ray_circle_intersection_top_defines.svh */
// Assertion macros used by the ray / circle intersection top level.
`ifndef RAY_CIRCLE_INTERSECTION_TOP_DEFINES_SVH
`define RAY_CIRCLE_INTERSECTION_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RCI_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define RCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rci_pkg.sv */
// Shared widths, constants and payload types of the ray / circle intersection block.
`default_nettype none

package rci_pkg;

  // Field widths
  localparam int unsigned CrdW   = 32;  // Q23.8 coordinate
  localparam int unsigned DirW   = 18;  // Q1.16 direction component
  localparam int unsigned RadW   = 31;  // radius register
  localparam int unsigned Lanes  = 3;   // x, y, z

  // Datapath widths
  localparam int unsigned AW     = 36;  // u*u + v*v
  localparam int unsigned HW     = 51;  // u*X + v*Y, signed
  localparam int unsigned HMagW  = 50;  // |h|
  localparam int unsigned SW     = 64;  // X*X + Y*Y
  localparam int unsigned R2W    = 62;  // R*R
  localparam int unsigned HalfW  = 25;  // split of |h| for squaring
  localparam int unsigned AcW    = 68;  // a times half of the offset term
  localparam int unsigned DiscW  = 100; // discriminant, even width for the root
  localparam int unsigned RootW  = 50;  // floor square root of the discriminant
  localparam int unsigned NW     = 52;  // root numerator, signed
  localparam int unsigned NMagW  = 51;  // |n|
  localparam int unsigned NLoW   = 26;  // split of |n| for the offset product
  localparam int unsigned A100W  = 53;  // a * segment length
  localparam int unsigned ScW    = 59;  // 256 * n for the segment test
  localparam int unsigned NumW   = 70;  // |d| * |n|
  localparam int unsigned QW     = 33;  // quotient bits kept before saturation

  // Constants
  localparam int unsigned SegLen    = 100000;
  localparam int unsigned RadiusRst = 256000;

  // Ray as it travels down the pipeline
  typedef struct packed {
    logic [CrdW-1:0] ox;
    logic [CrdW-1:0] oy;
    logic [CrdW-1:0] oz;
    logic [DirW-1:0] du;
    logic [DirW-1:0] dv;
    logic [DirW-1:0] dw;
  } ray_t;

  // Data carried alongside the square root
  typedef struct packed {
    ray_t             ray;
    logic [HW-1:0]    h;
    logic [AW-1:0]    a;
    logic [A100W-1:0] a100;
    logic             hit;
  } sq_sb_t;

  // Data carried alongside the divider
  typedef struct packed {
    logic [Lanes-1:0][CrdW-1:0] org;
    logic [Lanes-1:0]           neg;
    logic                       hit;
  } dv_sb_t;

  // Result beat
  typedef struct packed {
    logic [Lanes*CrdW-1:0] data;
    logic                  hit;
  } res_t;

endpackage

`default_nettype wire

/* hdl/rci_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module rci_sqrt #(
  parameter int unsigned SbW = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [rci_pkg::DiscW-1:0]    disc_i,
  input  wire logic [SbW-1:0]               sb_i,
  output logic                              valid_o,
  output logic [rci_pkg::RootW-1:0]         root_o,
  output logic [SbW-1:0]                    sb_o
);

  localparam int unsigned Steps = rci_pkg::RootW;
  localparam int unsigned RemW  = rci_pkg::RootW + 2;
  localparam int unsigned DW    = rci_pkg::DiscW;

  logic [RemW-1:0]          rem_q  [0:Steps-1];
  logic [rci_pkg::RootW-1:0] root_q [0:Steps-1];
  logic [DW-1:0]            dsh_q  [0:Steps-1];
  logic [SbW-1:0]           sb_q   [0:Steps-1];
  logic                     vld_q  [0:Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [RemW-1:0]           rem_in;
    logic [rci_pkg::RootW-1:0] root_in;
    logic [DW-1:0]             dsh_in;
    logic [SbW-1:0]            sb_in;
    logic                      vld_in;
    logic [RemW+1:0]           rem_t;
    logic [RemW+1:0]           trial;
    logic                      take;

    if (k == 0) begin : g_src
      assign rem_in  = '0;
      assign root_in = '0;
      assign dsh_in  = disc_i;
      assign sb_in   = sb_i;
      assign vld_in  = valid_i;
    end else begin : g_src
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign dsh_in  = dsh_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next bit pair, try (4*root + 1)
    assign rem_t = {rem_in, dsh_in[DW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = (rem_t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= RemW'(take ? rem_t - trial : rem_t);
        root_q[k] <= {root_in[rci_pkg::RootW-2:0], take};
        dsh_q[k]  <= {dsh_in[DW-3:0], 2'b00};
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign sb_o    = sb_q[Steps-1];

endmodule

`default_nettype wire

/* hdl/rci_div.sv */
// Pipelined three-lane restoring divider with a shared denominator and overflow flag.
`default_nettype none

module rci_div #(
  parameter int unsigned SbW = 1
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          en_i,
  input  wire logic                                          valid_i,
  input  wire logic [rci_pkg::Lanes-1:0][rci_pkg::NumW-1:0]  num_i,
  input  wire logic [rci_pkg::AW-1:0]                        den_i,
  input  wire logic [SbW-1:0]                                sb_i,
  output logic                                               valid_o,
  output logic [rci_pkg::Lanes-1:0][rci_pkg::QW-1:0]         quo_o,
  output logic [rci_pkg::Lanes-1:0]                          ovf_o,
  output logic [SbW-1:0]                                     sb_o
);

  localparam int unsigned L    = rci_pkg::Lanes;
  localparam int unsigned QW   = rci_pkg::QW;
  localparam int unsigned DenW = rci_pkg::AW;
  localparam int unsigned NumW = rci_pkg::NumW;

  // stage 0 is the overflow check, stages 1..QW produce one quotient bit each
  logic [L-1:0][DenW-1:0] rem_q [0:QW];
  logic [L-1:0][QW-1:0]   quo_q [0:QW];
  logic [L-1:0][QW-1:0]   nlo_q [0:QW];
  logic [L-1:0]           ovf_q [0:QW];
  logic [DenW-1:0]        den_q [0:QW];
  logic [SbW-1:0]         sb_q  [0:QW];
  logic                   vld_q [0:QW];

  // Overflow check: quotient would reach 2^QW
  logic [L-1:0]           ovf_w;
  logic [L-1:0][DenW-1:0] rem0_w;
  logic [L-1:0][QW-1:0]   nlo0_w;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      ovf_w[l]  = (num_i[l] >= NumW'({den_i, {QW{1'b0}}}));
      rem0_w[l] = num_i[l][QW +: DenW];
      nlo0_w[l] = num_i[l][QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0_w;
      quo_q[0] <= '0;
      nlo_q[0] <= nlo0_w;
      ovf_q[0] <= ovf_w;
      den_q[0] <= den_i;
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [L-1:0][DenW-1:0] rem_w;
    logic [L-1:0][QW-1:0]   quo_w;
    logic [L-1:0][QW-1:0]   nlo_w;

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      logic [DenW:0] rem_t;
      logic          take;
      for (int l = 0; l < L; l++) begin
        rem_t    = {rem_q[k-1][l], nlo_q[k-1][l][QW-1]};
        take     = (rem_t >= {1'b0, den_q[k-1]});
        rem_w[l] = DenW'(take ? rem_t - {1'b0, den_q[k-1]} : rem_t);
        quo_w[l] = {quo_q[k-1][l][QW-2:0], take};
        nlo_w[l] = {nlo_q[k-1][l][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_w;
        quo_q[k] <= quo_w;
        nlo_q[k] <= nlo_w;
        ovf_q[k] <= ovf_q[k-1];
        den_q[k] <= den_q[k-1];
        sb_q[k]  <= sb_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign sb_o    = sb_q[QW];

endmodule

`default_nettype wire

/* hdl/ray_circle_intersection_top.sv */
// Top level of the pipelined ray / circle intersection block.
//
// Usage:
//   s_axis: one ray per beat (origin Q23.8, direction Q1.16). m_axis: one
//   result per ray, in order: the crossing point (Q23.8, saturated) in tdata
//   and the hit flag in tuser. A miss returns the zero point with tuser low.
//   cfg_we_i/cfg_wdata_i write the circle radius; write it only while no ray
//   is in flight.
//   Throughput: one ray per cycle while the output buffer has room. A ray
//   accepted on s_axis passes the 50-stage square root and the 34-stage
//   divider plus the arithmetic stages around them, then enters the buffer.
//   Receiver stall: results collect in a two-beat output buffer; while it is
//   full the whole pipeline holds and s_axis_tready_o drops, nothing is lost
//   or repeated. With room in the buffer new rays keep entering while a
//   result waits.
//   Reset: all beats in flight are dropped, the buffer empties and the radius
//   returns to 256000 (1000.0 units).
`default_nettype none
`include "ray_circle_intersection_top_defines.svh"

module ray_circle_intersection_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // tdata: origin_x, origin_y, origin_z (32 each), dir_x, dir_y, dir_z (18 each), 2 pad
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire logic [151:0]            s_axis_tdata_i,
  // tdata: hit_x, hit_y, hit_z (32 each)
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  output logic [95:0]                  m_axis_tdata_o,
  // tuser: hit_found
  output logic                         m_axis_tuser_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [rci_pkg::RadW-1:0] cfg_wdata_i
);

  localparam int unsigned CrdW  = rci_pkg::CrdW;
  localparam int unsigned DirW  = rci_pkg::DirW;
  localparam int unsigned L     = rci_pkg::Lanes;
  localparam int unsigned AW    = rci_pkg::AW;
  localparam int unsigned HW    = rci_pkg::HW;
  localparam int unsigned HMagW = rci_pkg::HMagW;
  localparam int unsigned HalfW = rci_pkg::HalfW;
  localparam int unsigned SW    = rci_pkg::SW;
  localparam int unsigned R2W   = rci_pkg::R2W;
  localparam int unsigned AcW   = rci_pkg::AcW;
  localparam int unsigned DiscW = rci_pkg::DiscW;
  localparam int unsigned NW    = rci_pkg::NW;
  localparam int unsigned NMagW = rci_pkg::NMagW;
  localparam int unsigned NLoW  = rci_pkg::NLoW;
  localparam int unsigned A100W = rci_pkg::A100W;
  localparam int unsigned ScW   = rci_pkg::ScW;
  localparam int unsigned NumW  = rci_pkg::NumW;
  localparam int unsigned QW    = rci_pkg::QW;
  localparam int unsigned SumW  = CrdW + 3;

  localparam logic signed [SumW-1:0] SatMax = SumW'(2147483647);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sd2147483648);

  // Radius register
  logic [rci_pkg::RadW-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rci_pkg::RadW'(rci_pkg::RadiusRst);
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Pipeline advance and output buffer control
  logic       en;
  logic       push;
  logic       pop;
  logic [1:0] cnt_q;

  assign en              = (cnt_q != 2'd2);
  assign s_axis_tready_o = en;

  // Input unpack
  rci_pkg::ray_t ray_in;
  assign ray_in.ox = s_axis_tdata_i[31:0];
  assign ray_in.oy = s_axis_tdata_i[63:32];
  assign ray_in.oz = s_axis_tdata_i[95:64];
  assign ray_in.du = s_axis_tdata_i[113:96];
  assign ray_in.dv = s_axis_tdata_i[131:114];
  assign ray_in.dw = s_axis_tdata_i[149:132];

  // Valid chain of the arithmetic stages around the root and divider
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic sq_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
      {v7_q, v8_q, v9_q, v10_q, v11_q}     <= '0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= sq_vld;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  // Stage 1: squares and cross products
  logic signed [35:0]   uu_w, vv_w;
  logic signed [49:0]   ux_w, vy_w;
  logic signed [63:0]   xx_w, yy_w;
  logic [R2W-1:0]       rr_w;
  rci_pkg::ray_t        ray1_q;
  logic [AW-2:0]        uu1_q, vv1_q;
  logic signed [49:0]   ux1_q, vy1_q;
  logic [SW-1:0]        xx1_q, yy1_q;
  logic [R2W-1:0]       rr1_q;

  assign uu_w = $signed(ray_in.du) * $signed(ray_in.du);
  assign vv_w = $signed(ray_in.dv) * $signed(ray_in.dv);
  assign ux_w = $signed(ray_in.du) * $signed(ray_in.ox);
  assign vy_w = $signed(ray_in.dv) * $signed(ray_in.oy);
  assign xx_w = $signed(ray_in.ox) * $signed(ray_in.ox);
  assign yy_w = $signed(ray_in.oy) * $signed(ray_in.oy);
  assign rr_w = radius_q * radius_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray1_q <= ray_in;
      uu1_q  <= uu_w[AW-2:0];
      vv1_q  <= vv_w[AW-2:0];
      ux1_q  <= ux_w;
      vy1_q  <= vy_w;
      xx1_q  <= xx_w;
      yy1_q  <= yy_w;
      rr1_q  <= rr_w;
    end
  end

  // Stage 2: quadratic coefficients
  rci_pkg::ray_t      ray2_q;
  logic [AW-1:0]      a2_q;
  logic signed [HW-1:0] h2_q;
  logic [SW-1:0]      s2_q;
  logic [R2W-1:0]     r2_2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray2_q <= ray1_q;
      a2_q   <= AW'(uu1_q) + AW'(vv1_q);
      h2_q   <= HW'(ux1_q) + HW'(vy1_q);
      s2_q   <= xx1_q + yy1_q;
      r2_2_q <= rr1_q;
    end
  end

  // Stage 3: |h|, sign of X^2+Y^2-R^2 and its magnitude, a * segment length
  rci_pkg::ray_t        ray3_q;
  logic [AW-1:0]        a3_q;
  logic signed [HW-1:0] h3_q;
  logic [HMagW-1:0]     hmag3_q;
  logic                 ge3_q;
  logic [SW-1:0]        diff3_q;
  logic [A100W-1:0]     a100_3_q;
  logic                 ge_w;

  assign ge_w = (s2_q >= SW'(r2_2_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray3_q   <= ray2_q;
      a3_q     <= a2_q;
      h3_q     <= h2_q;
      hmag3_q  <= HMagW'(h2_q[HW-1] ? -h2_q : h2_q);
      ge3_q    <= ge_w;
      diff3_q  <= ge_w ? s2_q - SW'(r2_2_q) : SW'(r2_2_q) - s2_q;
      a100_3_q <= A100W'(a2_q) * A100W'(rci_pkg::SegLen);
    end
  end

  // Stage 4: partial products of h*h and a*|C|
  rci_pkg::ray_t        ray4_q;
  logic [AW-1:0]        a4_q;
  logic signed [HW-1:0] h4_q;
  logic                 ge4_q;
  logic [A100W-1:0]     a100_4_q;
  logic [2*HalfW-1:0]   pll4_q, plh4_q, phh4_q;
  logic [AcW-1:0]       pal4_q, pah4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray4_q   <= ray3_q;
      a4_q     <= a3_q;
      h4_q     <= h3_q;
      ge4_q    <= ge3_q;
      a100_4_q <= a100_3_q;
      pll4_q   <= (2*HalfW)'(hmag3_q[HalfW-1:0]) * (2*HalfW)'(hmag3_q[HalfW-1:0]);
      plh4_q   <= (2*HalfW)'(hmag3_q[HalfW-1:0]) * (2*HalfW)'(hmag3_q[HMagW-1:HalfW]);
      phh4_q   <= (2*HalfW)'(hmag3_q[HMagW-1:HalfW]) * (2*HalfW)'(hmag3_q[HMagW-1:HalfW]);
      pal4_q   <= AcW'(a3_q) * AcW'(diff3_q[31:0]);
      pah4_q   <= AcW'(a3_q) * AcW'(diff3_q[63:32]);
    end
  end

  // Stage 5: assemble h*h and a*|C|
  rci_pkg::ray_t        ray5_q;
  logic [AW-1:0]        a5_q;
  logic signed [HW-1:0] h5_q;
  logic                 ge5_q;
  logic [A100W-1:0]     a100_5_q;
  logic [DiscW-1:0]     hh5_q, ac5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray5_q   <= ray4_q;
      a5_q     <= a4_q;
      h5_q     <= h4_q;
      ge5_q    <= ge4_q;
      a100_5_q <= a100_4_q;
      hh5_q    <= (DiscW'(phh4_q) << (2*HalfW)) + (DiscW'(plh4_q) << (HalfW + 1))
                  + DiscW'(pll4_q);
      ac5_q    <= (DiscW'(pah4_q) << 32) + DiscW'(pal4_q);
    end
  end

  // Stage 6: discriminant and hit decision
  logic [DiscW:0]   dsub_w;
  logic [DiscW-1:0] disc_w;
  logic             hit_w;
  logic [DiscW-1:0] disc6_q;
  rci_pkg::sq_sb_t  sb6_q;

  always_comb begin
    dsub_w = {1'b0, hh5_q} - {1'b0, ac5_q};
    if (ge5_q) begin
      disc_w = dsub_w[DiscW-1:0];
      hit_w  = !dsub_w[DiscW];
    end else begin
      disc_w = hh5_q + ac5_q;
      hit_w  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc6_q      <= disc_w;
      sb6_q.ray    <= ray5_q;
      sb6_q.h      <= h5_q;
      sb6_q.a      <= a5_q;
      sb6_q.a100   <= a100_5_q;
      sb6_q.hit    <= hit_w && (disc_w != '0) && (a5_q != '0);
    end
  end

  // Square root of the discriminant
  logic [rci_pkg::RootW-1:0] sq_root;
  rci_pkg::sq_sb_t           sq_sb;

  rci_sqrt #(
    .SbW($bits(rci_pkg::sq_sb_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v6_q),
    .disc_i (disc6_q),
    .sb_i   (sb6_q),
    .valid_o(sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  // Stage 7: both root numerators
  logic signed [NW-1:0] hext_w;
  logic signed [NW-1:0] n1_7_q, n2_7_q;
  rci_pkg::sq_sb_t      sb7_q;

  assign hext_w = NW'($signed(sq_sb.h));

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_7_q <= NW'(sq_root) - hext_w;
      n2_7_q <= NW'(0) - NW'(sq_root) - hext_w;
      sb7_q  <= sq_sb;
    end
  end

  // Stage 8: pick the root that lies on the segment, the second root when both or neither do
  logic                 ok1_w, ok2_w;
  logic signed [NW-1:0] n8_q;
  rci_pkg::sq_sb_t      sb8_q;

  assign ok1_w = !n1_7_q[NW-1] && (n1_7_q != '0)
                 && ({n1_7_q[NW-2:0], 8'b0} < ScW'(sb7_q.a100));
  assign ok2_w = !n2_7_q[NW-1] && (n2_7_q != '0)
                 && ({n2_7_q[NW-2:0], 8'b0} < ScW'(sb7_q.a100));

  always_ff @(posedge clk_i) begin
    if (en) begin
      n8_q  <= (ok1_w && !ok2_w) ? n1_7_q : n2_7_q;
      sb8_q <= sb7_q;
    end
  end

  // Stage 9: magnitudes and signs of the offset factors
  logic [L-1:0][DirW-1:0] dir8_w;
  logic [NMagW-1:0]       nmag9_q;
  logic [L-1:0][DirW-1:0] dmag9_q;
  logic [AW-1:0]          a9_q;
  rci_pkg::dv_sb_t        dsb9_q;

  assign dir8_w = {sb8_q.ray.dw, sb8_q.ray.dv, sb8_q.ray.du};

  always_ff @(posedge clk_i) begin
    if (en) begin
      nmag9_q        <= NMagW'(n8_q[NW-1] ? -n8_q : n8_q);
      a9_q           <= sb8_q.a;
      dsb9_q.org     <= {sb8_q.ray.oz, sb8_q.ray.oy, sb8_q.ray.ox};
      dsb9_q.hit     <= sb8_q.hit;
      for (int l = 0; l < L; l++) begin
        dmag9_q[l]    <= DirW'(dir8_w[l][DirW-1] ? -dir8_w[l] : dir8_w[l]);
        dsb9_q.neg[l] <= dir8_w[l][DirW-1] ^ n8_q[NW-1];
      end
    end
  end

  // Stage 10: partial products of |d| * |n|
  logic [L-1:0][DirW+NLoW-1:0] pl10_q;
  logic [L-1:0][DirW+NLoW-1:0] ph10_q;
  logic [AW-1:0]               a10_q;
  rci_pkg::dv_sb_t             dsb10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a10_q   <= a9_q;
      dsb10_q <= dsb9_q;
      for (int l = 0; l < L; l++) begin
        pl10_q[l] <= (DirW+NLoW)'(dmag9_q[l]) * (DirW+NLoW)'(nmag9_q[NLoW-1:0]);
        ph10_q[l] <= (DirW+NLoW)'(dmag9_q[l]) * (DirW+NLoW)'(nmag9_q[NMagW-1:NLoW]);
      end
    end
  end

  // Stage 11: full numerators
  logic [L-1:0][NumW-1:0] num11_q;
  logic [AW-1:0]          a11_q;
  rci_pkg::dv_sb_t        dsb11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a11_q   <= a10_q;
      dsb11_q <= dsb10_q;
      for (int l = 0; l < L; l++) begin
        num11_q[l] <= (NumW'(ph10_q[l]) << NLoW) + NumW'(pl10_q[l]);
      end
    end
  end

  // Offsets |d*n| / a
  logic                   dv_vld;
  logic [L-1:0][QW-1:0]   dv_quo;
  logic [L-1:0]           dv_ovf;
  rci_pkg::dv_sb_t        dv_sb;

  rci_div #(
    .SbW($bits(rci_pkg::dv_sb_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v11_q),
    .num_i  (num11_q),
    .den_i  (a11_q),
    .sb_i   (dsb11_q),
    .valid_o(dv_vld),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf),
    .sb_o   (dv_sb)
  );

  // Final add with saturation, zero point on a miss
  rci_pkg::res_t res_w;

  always_comb begin
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] org;
    logic signed [SumW-1:0] off;
    logic [CrdW-1:0]        val;
    res_w.hit  = dv_sb.hit;
    res_w.data = '0;
    for (int l = 0; l < L; l++) begin
      org = SumW'($signed(dv_sb.org[l]));
      off = SumW'(dv_quo[l]);
      sum = dv_sb.neg[l] ? org - off : org + off;
      if (dv_ovf[l]) begin
        val = dv_sb.neg[l] ? SatMin[CrdW-1:0] : SatMax[CrdW-1:0];
      end else if (sum > SatMax) begin
        val = SatMax[CrdW-1:0];
      end else if (sum < SatMin) begin
        val = SatMin[CrdW-1:0];
      end else begin
        val = sum[CrdW-1:0];
      end
      res_w.data[l*CrdW +: CrdW] = dv_sb.hit ? val : '0;
    end
  end

  // Two-beat output buffer
  rci_pkg::res_t buf_q [0:1];
  logic          wr_q, rd_q;

  assign push = en && dv_vld;
  assign pop  = (cnt_q != 2'd0) && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res_w;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = buf_q[rd_q].data;
  assign m_axis_tuser_o  = buf_q[rd_q].hit;

  // Checks
  `RCI_ASSERT(a_buf_bound, clk_i, rst_ni, cnt_q != 2'd3, "output buffer overfilled")
  `RCI_ASSERT_NEXT(a_push_seen, clk_i, rst_ni, push, m_axis_tvalid_o, "pushed result not offered")
  `RCI_ASSERT(a_miss_zero, clk_i, rst_ni, !m_axis_tvalid_o || m_axis_tuser_o || (m_axis_tdata_o == '0), "miss with nonzero point")

endmodule

`default_nettype wire
